// ----- sv/hsl_pkg.sv -----
package hsl_pkg;

  localparam int unsigned FULL_SCALE = 256;
  localparam int unsigned SECTOR_DEG = 60;
  localparam int unsigned HUE_LIMIT  = 360;
  localparam int unsigned MAX5       = 31;
  localparam int unsigned MAX6       = 63;
  // floor(u / 15) as (u * RECIP15) >> 16, exact for u up to 960
  localparam int unsigned RECIP15    = 4370;

  // hue sectors, 60 degrees each
  localparam logic [2:0] SEC_RY = 3'd0;
  localparam logic [2:0] SEC_YG = 3'd1;
  localparam logic [2:0] SEC_GC = 3'd2;
  localparam logic [2:0] SEC_CB = 3'd3;
  localparam logic [2:0] SEC_BM = 3'd4;
  localparam logic [2:0] SEC_MR = 3'd5;

  typedef struct packed {
    logic [8:0] hue_deg;
    logic [8:0] saturation;
    logic [8:0] lightness;
  } hsl_in_t;

  typedef struct packed {
    logic [4:0]  red5;
    logic [5:0]  green6;
    logic [4:0]  blue5;
    logic [15:0] packed_color;
    logic        hue_error;
  } hsl_out_t;

  // after decode: lightness factor, clamped inputs, x weight, sector
  typedef struct packed {
    logic [8:0] a;
    logic [8:0] s;
    logic [8:0] l;
    logic [5:0] k;
    logic [2:0] sector;
    logic       err;
  } hsl_dec_t;

  // chroma scaled by 65536
  typedef struct packed {
    logic [16:0] c;
    logic [8:0]  l;
    logic [5:0]  k;
    logic [2:0]  sector;
    logic        err;
  } hsl_chr_t;

  // channel values over denominator 65536*60, top bits only
  typedef struct packed {
    logic [9:0] u_r;
    logic [9:0] u_g;
    logic [9:0] u_b;
    logic       err;
  } hsl_chan_t;

endpackage

// ----- sv/hsl_front.sv -----
module hsl_front import hsl_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     up_valid,
  output logic     up_ready,
  input  hsl_in_t  up_data,
  output logic     dn_valid,
  input  logic     dn_ready,
  output hsl_chr_t dn_data
);

  logic     v1_r, v2_r;
  logic     en1, en2;
  hsl_dec_t d1_r, d1_nxt;
  hsl_chr_t d2_r, d2_nxt;

  logic [9:0]  l2;
  logic [9:0]  l_gap;
  logic [8:0]  base;
  logic [8:0]  r_full;
  logic [5:0]  r;
  logic [17:0] prod;

  assign en2      = !v2_r || dn_ready;
  assign en1      = !v1_r || en2;
  assign up_ready = en1;

  always_comb begin
    d1_nxt.s = (up_data.saturation > 9'(FULL_SCALE)) ? 9'(FULL_SCALE) : up_data.saturation;
    d1_nxt.l = (up_data.lightness > 9'(FULL_SCALE)) ? 9'(FULL_SCALE) : up_data.lightness;
    l2    = {d1_nxt.l, 1'b0};
    l_gap = (l2 >= 10'(FULL_SCALE)) ? (l2 - 10'(FULL_SCALE)) : (10'(FULL_SCALE) - l2);
    d1_nxt.a   = 9'(10'(FULL_SCALE) - l_gap);
    d1_nxt.err = (up_data.hue_deg >= 9'(HUE_LIMIT));
    if (up_data.hue_deg < 9'(SECTOR_DEG)) begin
      d1_nxt.sector = SEC_RY;
    end else if (up_data.hue_deg < 9'(2 * SECTOR_DEG)) begin
      d1_nxt.sector = SEC_YG;
    end else if (up_data.hue_deg < 9'(3 * SECTOR_DEG)) begin
      d1_nxt.sector = SEC_GC;
    end else if (up_data.hue_deg < 9'(4 * SECTOR_DEG)) begin
      d1_nxt.sector = SEC_CB;
    end else if (up_data.hue_deg < 9'(5 * SECTOR_DEG)) begin
      d1_nxt.sector = SEC_BM;
    end else begin
      d1_nxt.sector = SEC_MR;
    end
    case (d1_nxt.sector)
      SEC_RY:  base = 9'd0;
      SEC_YG:  base = 9'(SECTOR_DEG);
      SEC_GC:  base = 9'(2 * SECTOR_DEG);
      SEC_CB:  base = 9'(3 * SECTOR_DEG);
      SEC_BM:  base = 9'(4 * SECTOR_DEG);
      default: base = 9'(5 * SECTOR_DEG);
    endcase
    // offset inside the sector; garbage for bad hue, masked at the end
    r_full = up_data.hue_deg - base;
    r      = r_full[5:0];
    // x rises in even sectors and falls in odd ones
    d1_nxt.k = d1_nxt.sector[0] ? (6'(SECTOR_DEG) - r) : r;
  end

  always_comb begin
    prod          = 18'(d1_r.a) * 18'(d1_r.s);
    d2_nxt.c      = prod[16:0];
    d2_nxt.l      = d1_r.l;
    d2_nxt.k      = d1_r.k;
    d2_nxt.sector = d1_r.sector;
    d2_nxt.err    = d1_r.err;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (en1) v1_r <= up_valid;
      if (en2) v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) d1_r <= d1_nxt;
    if (en2) d2_r <= d2_nxt;
  end

  assign dn_valid = v2_r;
  assign dn_data  = d2_r;

endmodule

// ----- sv/hsl_mix.sv -----
module hsl_mix import hsl_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      up_valid,
  output logic      up_ready,
  input  hsl_chr_t  up_data,
  output logic      dn_valid,
  input  logic      dn_ready,
  output hsl_chan_t dn_data
);

  logic        v3_r, v4_r;
  logic        en3, en4;
  logic [21:0] cd_r, xd_r, md_r, cd_nxt, xd_nxt, md_nxt;
  logic [2:0]  sec_r;
  logic        err_r;
  hsl_chan_t   d4_r, d4_nxt;

  logic [22:0] cd_w, xd_w;
  logic [21:0] lm, ch;
  logic [21:0] sel_red, sel_grn, sel_blu;
  logic [21:0] vr, vg, vb;

  assign en4      = !v4_r || dn_ready;
  assign en3      = !v3_r || en4;
  assign up_ready = en3;

  // all terms over denominator 65536*60
  always_comb begin
    cd_w   = 23'(up_data.c) * 23'(SECTOR_DEG);
    xd_w   = 23'(up_data.c) * 23'(up_data.k);
    cd_nxt = cd_w[21:0];
    xd_nxt = xd_w[21:0];
    lm     = 22'(up_data.l) * 22'(FULL_SCALE * SECTOR_DEG);
    ch     = 22'(up_data.c) * 22'(SECTOR_DEG / 2);
    md_nxt = lm - ch;
  end

  always_comb begin
    case (sec_r)
      SEC_RY: begin
        sel_red = cd_r; sel_grn = xd_r; sel_blu = '0;
      end
      SEC_YG: begin
        sel_red = xd_r; sel_grn = cd_r; sel_blu = '0;
      end
      SEC_GC: begin
        sel_red = '0; sel_grn = cd_r; sel_blu = xd_r;
      end
      SEC_CB: begin
        sel_red = '0; sel_grn = xd_r; sel_blu = cd_r;
      end
      SEC_BM: begin
        sel_red = xd_r; sel_grn = '0; sel_blu = cd_r;
      end
      default: begin
        sel_red = cd_r; sel_grn = '0; sel_blu = xd_r;
      end
    endcase
    vr = sel_red + md_r;
    vg = sel_grn + md_r;
    vb = sel_blu + md_r;
    // drop 12 bits: leaves a divide by 15 for the 6-bit code
    d4_nxt.u_r = vr[21:12];
    d4_nxt.u_g = vg[21:12];
    d4_nxt.u_b = vb[21:12];
    d4_nxt.err = err_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (en3) v3_r <= up_valid;
      if (en4) v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      cd_r  <= cd_nxt;
      xd_r  <= xd_nxt;
      md_r  <= md_nxt;
      sec_r <= up_data.sector;
      err_r <= up_data.err;
    end
    if (en4) d4_r <= d4_nxt;
  end

  assign dn_valid = v4_r;
  assign dn_data  = d4_r;

endmodule

// ----- sv/hsl_quant.sv -----
module hsl_quant import hsl_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      up_valid,
  output logic      up_ready,
  input  hsl_chan_t up_data,
  output logic      dn_valid,
  input  logic      dn_ready,
  output hsl_out_t  dn_data
);

  logic       v5_r;
  logic       en5;
  hsl_out_t   d5_r, d5_nxt;

  logic [22:0] pr, pg, pb;
  logic [6:0]  qr, qg, qb;
  logic [5:0]  hr, hb;
  logic [4:0]  r5, b5;
  logic [5:0]  g6;

  assign en5      = !v5_r || dn_ready;
  assign up_ready = en5;

  always_comb begin
    pr = 23'(up_data.u_r) * 23'(RECIP15);
    pg = 23'(up_data.u_g) * 23'(RECIP15);
    pb = 23'(up_data.u_b) * 23'(RECIP15);
    qr = pr[22:16];
    qg = pg[22:16];
    qb = pb[22:16];
    // 5-bit code is the 6-bit quotient halved
    hr = qr[6:1];
    hb = qb[6:1];
    r5 = (hr > 6'(MAX5)) ? 5'(MAX5) : hr[4:0];
    b5 = (hb > 6'(MAX5)) ? 5'(MAX5) : hb[4:0];
    g6 = (qg > 7'(MAX6)) ? 6'(MAX6) : qg[5:0];
    if (up_data.err) begin
      d5_nxt.red5         = '0;
      d5_nxt.green6       = '0;
      d5_nxt.blue5        = '0;
      d5_nxt.packed_color = '0;
      d5_nxt.hue_error    = 1'b1;
    end else begin
      d5_nxt.red5         = r5;
      d5_nxt.green6       = g6;
      d5_nxt.blue5        = b5;
      d5_nxt.packed_color = {r5, g6, b5};
      d5_nxt.hue_error    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (en5) begin
      v5_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en5) d5_r <= d5_nxt;
  end

  assign dn_valid = v5_r;
  assign dn_data  = d5_r;

endmodule

// ----- sv/hsl_to_rgb565.sv -----
// channel | direction | beat                  | handshake
// in_     | input     | hue, saturation, light | in_valid / in_stall
// out_    | output    | rgb565 and hue error   | out_valid / out_stall
//
// five register stages: decode, chroma multiply, c/x/m terms,
// channel sums, divide by 15 and pack; one beat in and one out per cycle
// while the output does not stall
// rst_n clears the stage valid bits only
// an output stall holds each full stage whose successors are all full;
// empty stages keep filling, so in_stall rises only when all five are full
module hsl_to_rgb565 import hsl_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  hsl_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output hsl_out_t out_data
);

  logic      fr_ready, fr_valid;
  hsl_chr_t  fr_data;
  logic      mx_ready, mx_valid;
  hsl_chan_t mx_data;
  logic      qt_ready;

  hsl_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_ready (fr_ready),
    .up_data  (in_data),
    .dn_valid (fr_valid),
    .dn_ready (mx_ready),
    .dn_data  (fr_data)
  );

  hsl_mix u_mix (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (fr_valid),
    .up_ready (mx_ready),
    .up_data  (fr_data),
    .dn_valid (mx_valid),
    .dn_ready (qt_ready),
    .dn_data  (mx_data)
  );

  hsl_quant u_quant (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (mx_valid),
    .up_ready (qt_ready),
    .up_data  (mx_data),
    .dn_valid (out_valid),
    .dn_ready (!out_stall),
    .dn_data  (out_data)
  );

  assign in_stall = !fr_ready;

  // input only backs up when the output beat is waiting
  a_stall_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while output side is free");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  a_pack_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.packed_color ==
                   {out_data.red5, out_data.green6, out_data.blue5}))
    else $error("packed word differs from channel codes");

  a_error_black: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.hue_error) |-> (out_data.packed_color == 16'd0))
    else $error("bad hue gave a nonzero color");

endmodule

// ----- sim/hsl_to_rgb565_test.sv -----
module hsl_to_rgb565_test;
  timeunit 1ns;
  timeprecision 1ps;

  import hsl_pkg::*;

  localparam longint unsigned SCALE_DEN = 65536 * 60;
  localparam int unsigned     STUCK_LIMIT = 3000;
  localparam int unsigned     HOLD_CYCLES = 300;
  localparam int unsigned     PHASE_PIXELS = 610;
  localparam int unsigned     PRESSURE_PIXELS = 40;
  localparam int unsigned     PRINT_LIMIT = 40;

  typedef struct {
    hsl_in_t  px;
    hsl_out_t color;
  } pending_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  hsl_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  hsl_out_t out_data;

  pending_t    pending_colors[$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit          hold_go = 1'b0;
  int unsigned hold_left = 0;
  int unsigned pixels_sent = 0;
  int unsigned bad_hue_sent = 0;
  int unsigned colors_seen = 0;
  int unsigned mismatches = 0;

  hsl_to_rgb565 i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #10 clk = ~clk;

  function automatic int unsigned scale_code(longint unsigned v, int unsigned mult,
                                             int unsigned top);
    longint unsigned q;
    q = (v * mult) / SCALE_DEN;
    return (q > top) ? top : int'(q);
  endfunction

  // exact rational conversion over 65536*60, truncated, then saturated
  function automatic hsl_out_t rgb565_of(hsl_in_t px);
    hsl_out_t        o;
    longint unsigned s, l, gap, chroma, fold, c_d, x_d, m_d, r_d, g_d, b_d;
    logic [2:0]      sector;
    o = '0;
    if (px.hue_deg >= HUE_LIMIT) begin
      o.hue_error = 1'b1;
      return o;
    end
    s = (px.saturation > FULL_SCALE) ? FULL_SCALE : px.saturation;
    l = (px.lightness > FULL_SCALE) ? FULL_SCALE : px.lightness;
    gap = (2 * l >= FULL_SCALE) ? 2 * l - FULL_SCALE : FULL_SCALE - 2 * l;
    chroma = (FULL_SCALE - gap) * s;
    fold = px.hue_deg % (2 * SECTOR_DEG);
    fold = (fold >= SECTOR_DEG) ? fold - SECTOR_DEG : SECTOR_DEG - fold;
    c_d = chroma * SECTOR_DEG;
    x_d = chroma * (SECTOR_DEG - fold);
    m_d = l * FULL_SCALE * SECTOR_DEG - chroma * (SECTOR_DEG / 2);
    sector = 3'(px.hue_deg / SECTOR_DEG);
    case (sector)
      SEC_RY: begin r_d = c_d; g_d = x_d; b_d = 0;   end
      SEC_YG: begin r_d = x_d; g_d = c_d; b_d = 0;   end
      SEC_GC: begin r_d = 0;   g_d = c_d; b_d = x_d; end
      SEC_CB: begin r_d = 0;   g_d = x_d; b_d = c_d; end
      SEC_BM: begin r_d = x_d; g_d = 0;   b_d = c_d; end
      default: begin r_d = c_d; g_d = 0;  b_d = x_d; end
    endcase
    o.red5   = 5'(scale_code(r_d + m_d, 32, MAX5));
    o.green6 = 6'(scale_code(g_d + m_d, 64, MAX6));
    o.blue5  = 5'(scale_code(b_d + m_d, 32, MAX5));
    o.packed_color = {o.red5, o.green6, o.blue5};
    return o;
  endfunction

  function automatic hsl_in_t pixel(int unsigned h, int unsigned s, int unsigned l);
    hsl_in_t px;
    px.hue_deg    = 9'(h);
    px.saturation = 9'(s);
    px.lightness  = 9'(l);
    return px;
  endfunction

  // mostly legal hsl with random content, some out-of-range hue and fractions
  function automatic hsl_in_t random_pixel();
    hsl_in_t     px;
    int unsigned pick;
    pick = $urandom_range(99);
    px.hue_deg = (pick < 8) ? 9'($urandom_range(511, 360)) : 9'($urandom_range(359, 0));
    pick = $urandom_range(99);
    if (pick < 10)      px.saturation = 9'($urandom_range(511, 257));
    else if (pick < 20) px.saturation = $urandom_range(1) ? 9'(FULL_SCALE) : 9'd0;
    else                px.saturation = 9'($urandom_range(FULL_SCALE, 0));
    pick = $urandom_range(99);
    if (pick < 10)      px.lightness = 9'($urandom_range(511, 257));
    else if (pick < 20) px.lightness = $urandom_range(1) ? 9'(FULL_SCALE) : 9'd0;
    else                px.lightness = 9'($urandom_range(FULL_SCALE, 0));
    return px;
  endfunction

  task automatic report_mismatch(string what, hsl_in_t px, int unsigned got,
                                 int unsigned want);
    if (mismatches < PRINT_LIMIT)
      $display("%0t: %s mismatch for hsl %0d/%0d/%0d: got %0h, want %0h", $realtime,
               what, px.hue_deg, px.saturation, px.lightness, got, want);
    mismatches++;
  endtask

  // called right after a rising edge; returns at the edge that takes the beat
  task automatic send_pixel(hsl_in_t px);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= px;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
    pending_colors.push_back('{px: px, color: rgb565_of(px)});
    pixels_sent++;
    if (px.hue_deg >= HUE_LIMIT) bad_hue_sent++;
  endtask

  task automatic check_color(hsl_out_t got);
    pending_t want;
    colors_seen++;
    if (pending_colors.size() == 0) begin
      report_mismatch("unexpected beat", '0, 32'(got.packed_color), 0);
      return;
    end
    want = pending_colors.pop_front();
    if (got.red5 !== want.color.red5)
      report_mismatch("red5", want.px, got.red5, want.color.red5);
    if (got.green6 !== want.color.green6)
      report_mismatch("green6", want.px, got.green6, want.color.green6);
    if (got.blue5 !== want.color.blue5)
      report_mismatch("blue5", want.px, got.blue5, want.color.blue5);
    if (got.packed_color !== want.color.packed_color)
      report_mismatch("packed_color", want.px, got.packed_color, want.color.packed_color);
    if (got.hue_error !== want.color.hue_error)
      report_mismatch("hue_error", want.px, got.hue_error, want.color.hue_error);
  endtask

  // receiver: random stall, or a long hold-off when asked
  always @(posedge clk) begin
    if (hold_go) begin
      hold_go = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // everything is stable at the falling edge, so sample there
  always @(negedge clk) begin
    if (rst_n && out_valid && !out_stall) check_color(out_data);
  end

  initial begin
    int unsigned stuck;
    stuck = 0;
    while (stuck < STUCK_LIMIT) begin
      @(negedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) stuck = 0;
      else stuck++;
    end
    $display("timeout: no beat moved for %0d cycles", STUCK_LIMIT);
    $display("hsl_to_rgb565 test failed");
    $finish;
  end

  task automatic test_corners();
    send_idle_pct = 34;
    recv_idle_pct = 60;
    // pure hues at both edges of every sector
    send_pixel(pixel(0, 256, 128));
    send_pixel(pixel(59, 256, 128));
    send_pixel(pixel(60, 256, 128));
    send_pixel(pixel(119, 256, 128));
    send_pixel(pixel(120, 256, 128));
    send_pixel(pixel(179, 256, 128));
    send_pixel(pixel(180, 256, 128));
    send_pixel(pixel(239, 256, 128));
    send_pixel(pixel(240, 256, 128));
    send_pixel(pixel(299, 256, 128));
    send_pixel(pixel(300, 256, 128));
    send_pixel(pixel(359, 256, 128));
    // gray, black, white and all-zero
    send_pixel(pixel(30, 0, 128));
    send_pixel(pixel(90, 256, 0));
    send_pixel(pixel(210, 256, 256));
    send_pixel(pixel(0, 0, 0));
    // fractions above full scale clamp to one
    send_pixel(pixel(150, 511, 64));
    send_pixel(pixel(270, 200, 511));
    send_pixel(pixel(330, 257, 257));
    // hue out of range gives black with the error flag; then two in-range pixels
    send_pixel(pixel(360, 256, 128));
    send_pixel(pixel(511, 511, 511));
    send_pixel(pixel(45, 128, 200));
    send_pixel(pixel(255, 1, 255));
  endtask

  task automatic test_random_pixels();
    int unsigned send_mix[3] = '{34, 60, 0};
    int unsigned recv_mix[3] = '{60, 34, 0};
    for (int p = 0; p < 3; p++) begin
      send_idle_pct = send_mix[p];
      recv_idle_pct = recv_mix[p];
      repeat (PHASE_PIXELS) send_pixel(random_pixel());
    end
  endtask

  // output held off while input keeps coming, so the pipe fills and stalls input
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_go = 1'b1;
    repeat (2) @(posedge clk);
    repeat (PRESSURE_PIXELS) send_pixel(random_pixel());
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_corners();
    test_random_pixels();
    test_backpressure();
    in_valid <= 1'b0;
    while (pending_colors.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("covered %0d pixels, %0d with hue out of range, %0d colors checked",
             pixels_sent, bad_hue_sent, colors_seen);
    $display("sector edges, clamped fractions, three idle mixes and a %0d-cycle hold-off",
             HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("hsl_to_rgb565 test passed");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("hsl_to_rgb565 test failed");
    end
    $finish;
  end

endmodule
